// File: design/ght_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_pkg: shared types for the generation handle slot table
// Payload structs, operation and status codes, slot entry layout, helpers.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int GEN_W      = 16;
  localparam int SOCK_W     = 16;
  localparam int HANDLE_W   = 32;
  localparam int SLOT_IDX_W = 6;

  typedef enum logic [1:0] {
    K_ALLOC    = 2'd0,
    K_FREE     = 2'd1,
    K_VALIDATE = 2'd2,
    K_FIND     = 2'd3
  } ght_kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OPEN = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } ght_status_t;

  typedef struct packed {
    ght_kind_t             kind;
    logic [SOCK_W-1:0]     sock_fd;
    logic [HANDLE_W-1:0]   handle;
  } ght_req_t;

  typedef struct packed {
    ght_status_t           status;
    logic [HANDLE_W-1:0]   handle_out;
    logic [SLOT_IDX_W-1:0] slot_index;
  } ght_rsp_t;

  // one RAM word per slot
  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic [SOCK_W-1:0] sock;
  } ght_entry_t;

  localparam int ENTRY_W = $bits(ght_entry_t);

  // first-hit results of one pass over the table
  typedef struct packed {
    logic                  sock_hit;   // first slot with matching socket
    logic [SLOT_IDX_W-1:0] sock_idx;
    logic [GEN_W-1:0]      sock_gen;
    logic                  sock_used;
    logic                  fresh_hit;  // first unused slot, generation zero
    logic [SLOT_IDX_W-1:0] fresh_idx;
    logic [GEN_W-1:0]      fresh_gen;
    logic                  free_hit;   // first unused slot
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [GEN_W-1:0]      free_gen;
    logic                  live_hit;   // first used slot with matching socket
    logic [SLOT_IDX_W-1:0] live_idx;
    logic [GEN_W-1:0]      live_gen;
    logic                  tgt_used;   // slot named by a handle
    logic [GEN_W-1:0]      tgt_gen;
  } ght_scan_t;

  // generation bump, wrap skips zero
  function automatic logic [GEN_W-1:0] gen_bump(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

  function automatic logic [HANDLE_W-1:0] slot_handle(input logic [SLOT_IDX_W-1:0] idx,
                                                      input logic [GEN_W-1:0] gen);
    logic [15:0] low;
    low = 16'(idx) + 16'd1;
    return {gen, low};
  endfunction

endpackage

// File: design/ght_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_stream_if: valid/ready channel
// One beat moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface ght_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/ght_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_ram: generic single-write, single-read RAM
// Registered read; no reset on the array.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ght_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_scan: first-hit tracker for one pass over the slot table
// Takes one slot per cycle and keeps the first hit of each search.
// ----------------------------------------------------------------------------
module ght_scan import ght_pkg::*; #(
  parameter int SLOT_COUNT = 8,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              chk_vld,
  input  logic [IDX_W-1:0]  chk_idx,
  input  ght_entry_t        entry,
  input  logic              used_bit,
  input  logic [SOCK_W-1:0] sock,
  input  logic [IDX_W-1:0]  tgt_idx,
  output ght_scan_t         sum
);

  logic sock_eq;
  logic [SLOT_IDX_W-1:0] idx6;

  assign sock_eq = (entry.sock == sock);
  assign idx6    = SLOT_IDX_W'(chk_idx);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      sum.sock_hit  <= 1'b0;
      sum.fresh_hit <= 1'b0;
      sum.free_hit  <= 1'b0;
      sum.live_hit  <= 1'b0;
    end else if (chk_vld) begin
      if (!sum.sock_hit && sock_eq) begin
        sum.sock_hit  <= 1'b1;
        sum.sock_idx  <= idx6;
        sum.sock_gen  <= entry.gen;
        sum.sock_used <= used_bit;
      end
      if (!sum.fresh_hit && !used_bit && entry.gen == '0) begin
        sum.fresh_hit <= 1'b1;
        sum.fresh_idx <= idx6;
        sum.fresh_gen <= entry.gen;
      end
      if (!sum.free_hit && !used_bit) begin
        sum.free_hit <= 1'b1;
        sum.free_idx <= idx6;
        sum.free_gen <= entry.gen;
      end
      if (!sum.live_hit && used_bit && sock_eq) begin
        sum.live_hit <= 1'b1;
        sum.live_idx <= idx6;
        sum.live_gen <= entry.gen;
      end
      if (chk_idx == tgt_idx) begin
        sum.tgt_used <= used_bit;
        sum.tgt_gen  <= entry.gen;
      end
    end
  end

endmodule

// File: design/generation_handle_slot_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generation_handle_slot_table_top: generational handle slot table
// Allocates, frees, validates and looks up 32-bit handles over a table of
// connection slots kept in a RAM, one full table pass per request.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload                       | handshake
//  --------+-----+------------------------------------+------------
//  req     | in  | kind, sock_fd, handle              | valid/ready
//  rsp     | out | status, handle_out, slot_index     | valid/ready
//
// Sequence: set by the single RAM read port, the pass issues one slot read a
//   cycle, a drain step covers the read latency, a decide step writes back,
//   and the sequencer then returns to idle.
// Reset: clears the used marks, the RAM written marks and the response
//   valid; unwritten RAM words read as zero, so no clearing pass is needed.
// Stalls: the response sits in an output register; the next request is taken
//   while it waits, and only its decide step holds until the register frees.
// ----------------------------------------------------------------------------
module generation_handle_slot_table_top import ght_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input logic         clk,
  input logic         rst,
  ght_stream_if.sink   req,
  ght_stream_if.source rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t             state;
  ght_req_t           cur;          // request being worked on
  logic [IDX_W-1:0]   ptr;          // RAM read address during the pass
  logic               chk_vld;      // RAM read data valid this cycle
  logic [IDX_W-1:0]   chk_idx;
  logic               start;

  logic [SLOT_COUNT-1:0] used;      // slot in use
  logic [SLOT_COUNT-1:0] written;   // RAM word holds real data

  logic [ENTRY_W-1:0] ram_rdata;
  ght_entry_t         entry;
  ght_entry_t         ram_wdata;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;

  ght_scan_t          sum;

  // handle decode for validate
  logic [15:0]        h_low;
  logic [15:0]        h_lowm1;
  logic               h_in_rng;
  logic [IDX_W-1:0]   tgt_idx;

  // decide step
  logic               out_free;
  logic               commit;
  ght_rsp_t           res;
  logic               do_claim;     // write new generation and socket
  logic               do_set;       // mark slot used
  logic               do_clr;       // mark slot unused
  logic [SLOT_IDX_W-1:0] act_idx;
  logic [GEN_W-1:0]   claim_gen;

  assign req.ready = (state == S_IDLE);
  assign start     = req.valid && req.ready;

  assign h_low    = cur.handle[15:0];
  assign h_lowm1  = h_low - 16'd1;
  assign h_in_rng = (h_low != '0) && (17'(h_lowm1) < 17'(SLOT_COUNT));
  assign tgt_idx  = h_lowm1[IDX_W-1:0];

  ght_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  // never-written words read as the reset value
  assign entry = written[chk_idx] ? ght_entry_t'(ram_rdata) : '0;

  ght_scan #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .chk_vld  (chk_vld),
    .chk_idx  (chk_idx),
    .entry    (entry),
    .used_bit (used[chk_idx]),
    .sock     (cur.sock_fd),
    .tgt_idx  (tgt_idx),
    .sum      (sum)
  );

  assign out_free = !rsp.valid || rsp.ready;
  assign commit   = (state == S_DECIDE) && out_free;

  // outcome of the request from the pass summary
  always_comb begin
    res       = '{status: ST_NONE, handle_out: '0, slot_index: '0};
    do_claim  = 1'b0;
    do_set    = 1'b0;
    do_clr    = 1'b0;
    act_idx   = '0;
    claim_gen = '0;
    unique case (cur.kind)
      K_ALLOC: begin
        priority if (sum.sock_hit) begin
          act_idx = sum.sock_idx;
          if (sum.sock_used) begin
            res = '{status: ST_OPEN, handle_out: '0, slot_index: sum.sock_idx};
          end else begin
            do_set = 1'b1;
            res = '{status: ST_OK, handle_out: slot_handle(sum.sock_idx, sum.sock_gen),
                    slot_index: sum.sock_idx};
          end
        end else if (sum.fresh_hit) begin
          act_idx   = sum.fresh_idx;
          claim_gen = gen_bump(sum.fresh_gen);
          do_claim  = 1'b1;
          do_set    = 1'b1;
          res = '{status: ST_OK, handle_out: slot_handle(sum.fresh_idx, claim_gen),
                  slot_index: sum.fresh_idx};
        end else if (sum.free_hit) begin
          act_idx   = sum.free_idx;
          claim_gen = gen_bump(sum.free_gen);
          do_claim  = 1'b1;
          do_set    = 1'b1;
          res = '{status: ST_OK, handle_out: slot_handle(sum.free_idx, claim_gen),
                  slot_index: sum.free_idx};
        end else begin
          res = '{status: ST_FULL, handle_out: '0, slot_index: '0};
        end
      end
      K_FREE, K_FIND: begin
        if (sum.live_hit) begin
          act_idx = sum.live_idx;
          do_clr  = (cur.kind == K_FREE);
          res = '{status: ST_OK, handle_out: slot_handle(sum.live_idx, sum.live_gen),
                  slot_index: sum.live_idx};
        end
      end
      K_VALIDATE: begin
        if (h_in_rng && sum.tgt_used && sum.tgt_gen == cur.handle[31:16]) begin
          res = '{status: ST_OK, handle_out: cur.handle,
                  slot_index: SLOT_IDX_W'(tgt_idx)};
        end
      end
      default: ;
    endcase
  end

  assign ram_we    = commit && do_claim;
  assign ram_waddr = act_idx[IDX_W-1:0];
  assign ram_wdata = '{gen: claim_gen, sock: cur.sock_fd};

  // sequencer, slot marks and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chk_vld   <= 1'b0;
      used      <= '0;
      written   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      chk_vld <= (state == S_SCAN);
      // a new beat loads in the same cycle the old one leaves
      if (commit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ptr == IDX_W'(SLOT_COUNT - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (commit && do_set) begin
        used[act_idx[IDX_W-1:0]] <= 1'b1;
      end
      if (commit && do_clr) begin
        used[act_idx[IDX_W-1:0]] <= 1'b0;
      end
      if (ram_we) begin
        written[ram_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx <= ptr;
    if (start) begin
      cur <= req.data;
      ptr <= '0;
    end else if (state == S_SCAN && ptr != IDX_W'(SLOT_COUNT - 1)) begin
      ptr <= ptr + IDX_W'(1);
    end
    if (commit) begin
      rsp.data <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_ok_handle_names_slot: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.status == ST_OK) |-> (rsp.data.handle_out[15:0] != '0))
    else $error("ok response with handle naming no slot");

  a_fail_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.status != ST_OK) |-> (rsp.data.handle_out == '0))
    else $error("failed response carries a handle");

  a_claim_gen_nonzero: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_wdata.gen != '0))
    else $error("slot claimed with generation zero");

  a_claim_marks_written: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (written[$past(ram_waddr)] && used[$past(ram_waddr)]))
    else $error("claimed slot not marked written and used");

endmodule
